@@ sv/upi_pkg.sv @@
// Package for the unicycle pose integrator: microcode word types, step codes,
// the microprogram and the constant function that builds the quarter-wave sine table.
// Depends on nothing; the top level and upi_sine_rom import it.
`timescale 1ns / 1ps

package upi_pkg;

    // Default number of entries in the quarter-wave sine table.
    localparam int SINE_ENTRIES_DEF = 1024;

    // Pi in Q30 and one in Q30, as used to build the table.
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;
    localparam logic [63:0] Q15_MAX = 64'd32767;

    // A quarter turn in binary angle units.
    localparam logic [15:0] QUARTER_TURN = 16'd16384;

    // Program steps.
    typedef logic [3:0] step_t;
    localparam step_t STEP_IDLE    = 4'd0;
    localparam step_t STEP_DIST    = 4'd1;
    localparam step_t STEP_COS     = 4'd2;
    localparam step_t STEP_DX      = 4'd3;
    localparam step_t STEP_DY      = 4'd4;
    localparam step_t STEP_ADDX    = 4'd5;
    localparam step_t STEP_ADDY    = 4'd6;
    localparam step_t STEP_DH      = 4'd7;
    localparam step_t STEP_ADDH    = 4'd8;
    localparam step_t STEP_PUBLISH = 4'd9;

    // Hold conditions: the step counter stays put while the condition is true.
    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_IN,
        HOLD_OUT
    } hold_t;

    // Multiplier operand A.
    typedef enum logic {
        OPA_DT,
        OPA_DIST
    } opa_t;

    // Multiplier operand B.
    typedef enum logic [1:0] {
        OPB_SPEED,
        OPB_TRIG,
        OPB_TURN
    } opb_t;

    // Which angle the sine table looks up.
    typedef enum logic {
        ROM_COS,
        ROM_SIN
    } rom_sel_t;

    // Rounding shift applied to the product register.
    typedef enum logic [1:0] {
        RND_NONE,
        RND_31,
        RND_16
    } rnd_t;

    // Accumulator written from the rounded value.
    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_X,
        ACC_Y,
        ACC_HEAD
    } acc_t;

    // One control word of the microprogram.
    typedef struct packed {
        hold_t    hold;
        logic     take_in;
        logic     mul_en;
        opa_t     opa;
        opb_t     opb;
        rom_sel_t rom_sel;
        logic     trig_ld;
        logic     dist_ld;
        rnd_t     rnd;
        acc_t     acc;
        logic     time_en;
        logic     publish;
        logic     jump;
        step_t    target;
    } ctl_word_t;

    // The microprogram. The cosine is read one step ahead of the sine so that
    // the shared multiplier is busy back to back on the two products.
    function automatic ctl_word_t upi_ucode(input step_t step);
        ctl_word_t w;
        w = '0;
        case (step)
            STEP_IDLE:
            begin
                w.hold    = HOLD_IN;
                w.take_in = 1'b1;
            end
            STEP_DIST:
            begin
                w.mul_en  = 1'b1;
                w.opa     = OPA_DT;
                w.opb     = OPB_SPEED;
                w.rom_sel = ROM_COS;
            end
            STEP_COS:
            begin
                w.dist_ld = 1'b1;
                w.trig_ld = 1'b1;
                w.rom_sel = ROM_SIN;
            end
            STEP_DX:
            begin
                w.mul_en  = 1'b1;
                w.opa     = OPA_DIST;
                w.opb     = OPB_TRIG;
                w.trig_ld = 1'b1;
            end
            STEP_DY:
            begin
                w.mul_en = 1'b1;
                w.opa    = OPA_DIST;
                w.opb    = OPB_TRIG;
                w.rnd    = RND_31;
            end
            STEP_ADDX:
            begin
                w.acc = ACC_X;
                w.rnd = RND_31;
            end
            STEP_ADDY:
            begin
                w.acc    = ACC_Y;
                w.mul_en = 1'b1;
                w.opa    = OPA_DT;
                w.opb    = OPB_TURN;
            end
            STEP_DH:
            begin
                w.rnd = RND_16;
            end
            STEP_ADDH:
            begin
                w.acc     = ACC_HEAD;
                w.time_en = 1'b1;
            end
            STEP_PUBLISH:
            begin
                w.hold    = HOLD_OUT;
                w.publish = 1'b1;
                w.jump    = 1'b1;
                w.target  = STEP_IDLE;
            end
            default:
            begin
                w.jump   = 1'b1;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    // Sine of a Q30 angle in [0, pi/2] by a Taylor series up to x^13,
    // scaled to Q15, rounded half up and capped. Evaluated at elaboration only.
    function automatic logic [14:0] sine_q15(input logic [63:0] ang);
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] q;
        term = ang;
        sum  = ang;
        for (int k = 1; k <= 6; k++)
        begin
            term = (term * ang) >> 30;
            term = (term * ang) >> 30;
            case (k)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                default: term = term / 64'd156;
            endcase
            if ((k % 2) == 1)
            begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end
            else
            begin
                sum = sum + term;
            end
        end
        q = (sum * Q15_MAX + (ONE_Q30 >> 1)) >> 30;
        if (q > Q15_MAX)
        begin
            q = Q15_MAX;
        end
        return q[14:0];
    endfunction

endpackage

@@ sv/upi_in_if.sv @@
// Input channel of the pose integrator: valid/ready handshake carrying one motion step.
// Depends on nothing.
`timescale 1ns / 1ps

interface upi_in_if;
    logic               valid;
    logic               ready;
    logic        [15:0] step_time;
    logic signed [15:0] speed;
    logic signed [15:0] turn_rate;

    modport source (output valid, output step_time, output speed, output turn_rate,
                    input ready);
    modport sink   (input valid, input step_time, input speed, input turn_rate,
                    output ready);
endinterface

@@ sv/upi_out_if.sv @@
// Output channel of the pose integrator: valid/ready handshake carrying one pose.
// Depends on nothing.
`timescale 1ns / 1ps

interface upi_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic        [47:0] elapsed;

    modport source (output valid, output pos_x, output pos_y, output heading,
                    output elapsed, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input heading,
                    input elapsed, output ready);
endinterface

@@ sv/unicycle_pose_integrator.sv @@
// Top level of the unicycle pose integrator: microprogram sequencer and shared datapath.
// Depends on upi_pkg, the channel interfaces upi_in_if and upi_out_if, and upi_sine_rom.
`timescale 1ns / 1ps

// Dead-reckoning odometry for a unicycle model. Each transfer on the cmd channel
// carries a time step (step_time), a forward speed and a turn rate. The block moves
// its pose with the heading it held before the step: x and y advance by
// step_time*speed times the cosine and sine of that heading, the heading adds the
// step_time*turn_rate, shifted right by 16 bits and rounded, as a binary angle that
// wraps on its own, and the elapsed time adds step_time. Every command produces
// exactly one transfer on the pose channel with the new x, y, heading and elapsed time.
// Timing: a command is taken only while the sequencer sits in its idle step. The
// sequencer then steps through DIST, COS, DX, DY, ADDX, ADDY, DH, ADDH and PUBLISH,
// where the result and its valid are loaded into the output register once it is free,
// and then returns to idle; a new command is taken only once the last is through. The
// ten-word microprogram drives the single 32x16 multiplier through the distance, the
// two trigonometric products and the heading product.
// When the receiver stalls, the finished pose waits in the output register while the
// next command is already taken and worked on; the sequencer waits in its final step
// only if that register is still full when a second result is ready.
// Reset clears the pose and elapsed time to zero, empties the output register and
// returns the sequencer to its idle step. The sine table is constant and needs no
// initialization pass.

module unicycle_pose_integrator
    import upi_pkg::*;
#(
    parameter int SINE_TABLE_ENTRIES = SINE_ENTRIES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    upi_in_if.sink       cmd,
    upi_out_if.source    pose
);

    // Sequencer.
    step_t     pc_reg;
    step_t     pc_next;
    ctl_word_t ctl;
    logic      hold;
    logic      take;
    logic      out_load;

    // Captured command.
    logic        [15:0] dt_reg;
    logic signed [15:0] speed_reg;
    logic signed [15:0] turn_reg;

    // Datapath registers.
    logic signed [31:0] dist_reg;
    logic signed [15:0] trig_reg;
    logic signed [47:0] prod_reg;
    logic signed [31:0] rnd_reg;

    // Pose state.
    logic signed [31:0] x_reg;
    logic signed [31:0] y_reg;
    logic        [15:0] head_reg;
    logic        [47:0] time_reg;

    // Output register.
    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [31:0] out_x_reg;
    logic signed [31:0] out_y_reg;
    logic        [15:0] out_head_reg;
    logic        [47:0] out_time_reg;

    // Combinational datapath.
    logic        [15:0] rom_angle;
    logic signed [15:0] rom_q;
    logic signed [31:0] mul_a;
    logic signed [15:0] mul_b;
    logic signed [47:0] mul_p;
    logic signed [48:0] prod_ext;
    logic signed [48:0] bias31;
    logic signed [48:0] bias16;
    logic signed [48:0] sum31;
    logic signed [48:0] sum16;
    logic signed [48:0] shr31;
    logic signed [48:0] shr16;

    assign ctl = upi_ucode(pc_reg);

    // The step counter waits for a command in the idle step and for a free output
    // register in the final step; otherwise it advances or jumps.
    always_comb
    begin
        case (ctl.hold)
            HOLD_IN:  hold = !cmd.valid;
            HOLD_OUT: hold = out_valid_reg && !pose.ready;
            default:  hold = 1'b0;
        endcase

        take     = ctl.take_in && cmd.valid;
        out_load = ctl.publish && !hold;

        if (hold)
        begin
            pc_next = pc_reg;
        end
        else if (ctl.jump)
        begin
            pc_next = ctl.target;
        end
        else
        begin
            pc_next = pc_reg + 4'd1;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pose.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign cmd.ready = ctl.take_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= STEP_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Sine table lookup; cosine is the sine a quarter turn further on.
    assign rom_angle = (ctl.rom_sel == ROM_COS) ? (head_reg + QUARTER_TURN) : head_reg;

    upi_sine_rom #(
        .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
    ) u_sine_rom (
        .clk   (clk),
        .angle (rom_angle),
        .sine  (rom_q)
    );

    // Shared multiplier and operand selection.
    always_comb
    begin
        case (ctl.opa)
            OPA_DIST: mul_a = dist_reg;
            default:  mul_a = $signed({16'd0, dt_reg});
        endcase

        case (ctl.opb)
            OPB_TRIG: mul_b = trig_reg;
            OPB_TURN: mul_b = turn_reg;
            default:  mul_b = speed_reg;
        endcase

        mul_p = mul_a * mul_b;
    end

    // Round to nearest with halves away from zero: a negative value takes a bias
    // one below the half, then an arithmetic shift floors both cases correctly.
    always_comb
    begin
        prod_ext = 49'(prod_reg);
        bias31   = prod_reg[47] ? 49'sh3FFF_FFFF : 49'sh4000_0000;
        bias16   = prod_reg[47] ? 49'sh7FFF : 49'sh8000;
        sum31    = prod_ext + bias31;
        sum16    = prod_ext + bias16;
        shr31    = sum31 >>> 31;
        shr16    = sum16 >>> 16;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            dt_reg    <= cmd.step_time;
            speed_reg <= cmd.speed;
            turn_reg  <= cmd.turn_rate;
        end

        if (ctl.mul_en)
        begin
            prod_reg <= mul_p;
        end

        if (ctl.dist_ld)
        begin
            dist_reg <= prod_reg[31:0];
        end

        if (ctl.trig_ld)
        begin
            trig_reg <= rom_q;
        end

        case (ctl.rnd)
            RND_31:  rnd_reg <= shr31[31:0];
            RND_16:  rnd_reg <= shr16[31:0];
            default: rnd_reg <= rnd_reg;
        endcase

        if (out_load)
        begin
            out_x_reg    <= x_reg;
            out_y_reg    <= y_reg;
            out_head_reg <= head_reg;
            out_time_reg <= time_reg;
        end
    end

    // Pose state, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            y_reg    <= '0;
            head_reg <= '0;
            time_reg <= '0;
        end
        else
        begin
            case (ctl.acc)
                ACC_X:    x_reg    <= x_reg + rnd_reg;
                ACC_Y:    y_reg    <= y_reg + rnd_reg;
                ACC_HEAD: head_reg <= head_reg + rnd_reg[15:0];
                default:  x_reg    <= x_reg;
            endcase
            if (ctl.time_en)
            begin
                time_reg <= time_reg + {32'd0, dt_reg};
            end
        end
    end

    assign pose.valid   = out_valid_reg;
    assign pose.pos_x   = out_x_reg;
    assign pose.pos_y   = out_y_reg;
    assign pose.heading = out_head_reg;
    assign pose.elapsed = out_time_reg;

    // A command is only taken while the sequencer is idle.
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ready |-> pc_reg == STEP_IDLE)
        else $error("command taken outside the idle step");

    // A result is never loaded over one that the receiver has not taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || pose.ready))
        else $error("output register overwritten");

    // The heading only moves in its accumulate step, so both lookups see the old one.
    a_head_stable: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.acc != ACC_HEAD |=> $stable(head_reg))
        else $error("heading changed outside its update step");

    // Elapsed time only moves in its update step.
    a_time_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.time_en |=> $stable(time_reg))
        else $error("elapsed time changed outside its update step");

endmodule

@@ sv/upi_sine_rom.sv @@
// Quarter-wave sine lookup for binary angles with a registered signed Q15 result.
// Depends on upi_pkg for the table-building function and constants.
`timescale 1ns / 1ps

module upi_sine_rom
    import upi_pkg::*;
#(
    parameter int SINE_TABLE_ENTRIES = SINE_ENTRIES_DEF
)
(
    input  logic               clk,
    input  logic        [15:0] angle,
    output logic signed [15:0] sine
);

    localparam int IDX_W  = $clog2(SINE_TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int PROD_W = 15 + CNT_W;
    localparam int FULL_W = PROD_W - 14;

    logic        [14:0] sine_tab [SINE_TABLE_ENTRIES];
    logic        [14:0] offset;
    logic  [PROD_W-1:0] scaled;
    logic  [FULL_W-1:0] idx_full;
    logic               at_peak;
    logic signed [15:0] mag;
    logic signed [15:0] sine_reg;

    // Constant table, entry g holds sin(pi/2 * g / entries) in Q15.
    for (genvar g = 0; g < SINE_TABLE_ENTRIES; g++)
    begin : g_tab
        localparam logic [63:0] ANG = (64'(g) * PI_Q30) / 64'(2 * SINE_TABLE_ENTRIES);
        assign sine_tab[g] = sine_q15(ANG);
    end

    // Odd quadrants mirror the offset; the top bit of the angle flips the sign.
    always_comb
    begin
        offset   = angle[14] ? (15'(QUARTER_TURN) - {1'b0, angle[13:0]})
                             : {1'b0, angle[13:0]};
        scaled   = PROD_W'(offset) * PROD_W'(SINE_TABLE_ENTRIES);
        idx_full = scaled[PROD_W-1:14];
        at_peak  = (idx_full >= FULL_W'(SINE_TABLE_ENTRIES));
    end

    always_ff @(posedge clk)
    begin
        if (at_peak)
        begin
            mag <= 16'(Q15_MAX);
        end
        else
        begin
            mag <= {1'b0, sine_tab[idx_full[IDX_W-1:0]]};
        end
    end

    // Sign is applied on the read data; the sign bit of the angle is registered alongside it.
    logic neg_reg;

    always_ff @(posedge clk)
    begin
        neg_reg <= angle[15];
    end

    always_comb
    begin
        sine_reg = neg_reg ? -mag : mag;
    end

    assign sine = sine_reg;

endmodule
